### rtl/ssfr_pkg.sv
package ssfr_pkg;

  // Field widths fixed by the item format.
  localparam int ENTRY_W = 13;
  localparam int VALUE_W = 64;

  // Widest table address and entry number over the supported table sizes.
  localparam int ADDR_MAX_W = 16;
  localparam int NUM_MAX_W  = 17;

  // Default table sizes.
  localparam int DEFAULT_MAX_ROWS = 4096;
  localparam int DEFAULT_MAX_COLS = 4096;

  // Queue depths between the front, the back and the result port.
  localparam int CMD_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH = 4;

  // Input item kinds.
  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_ROW     = 2'd1,
    KIND_COL     = 2'd2,
    KIND_TRIPLET = 2'd3
  } kind_t;

  // Operations handed from the front to the back.
  typedef enum logic [1:0] {
    OP_WR_ROW = 2'd0,
    OP_WR_COL = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [ADDR_MAX_W-1:0] row_addr;
    logic [ADDR_MAX_W-1:0] col_addr;
    logic [NUM_MAX_W-1:0]  number;
    logic [VALUE_W-1:0]    value;
  } cmd_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] new_row;
    logic [ENTRY_W-1:0] new_col;
    logic [VALUE_W-1:0] out_value;
  } res_t;

endpackage

### rtl/ssfr_fifo.sv
module ssfr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [WIDTH-1:0]             wr_data,
  input  logic                         rd_en,
  output logic [WIDTH-1:0]             rd_data,
  output logic                         full,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  // Storage slots carry no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

### rtl/ssfr_front.sv
module ssfr_front #(
  parameter int MAX_ROWS = 4096,
  parameter int MAX_COLS = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    kind,
  input  logic                          keep_flag,
  input  logic [ssfr_pkg::ENTRY_W-1:0]  entry_row,
  input  logic [ssfr_pkg::ENTRY_W-1:0]  entry_col,
  input  logic [ssfr_pkg::VALUE_W-1:0]  entry_value,
  input  logic                          cmd_full,
  output logic                          cmd_push,
  output ssfr_pkg::cmd_t                cmd
);

  import ssfr_pkg::*;

  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);

  logic [RCW-1:0]     rows_loaded, rows_loaded_next;
  logic [RCW-1:0]     rows_kept, rows_kept_next;
  logic [CCW-1:0]     cols_loaded, cols_loaded_next;
  logic [CCW-1:0]     cols_kept, cols_kept_next;
  logic               accept;
  logic               row_ok;
  logic               col_ok;
  logic [ENTRY_W-1:0] row_idx;
  logic [ENTRY_W-1:0] col_idx;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  // Range checks of a triplet against the masks loaded so far.
  assign row_ok  = (entry_row != '0) &&
                   (NUM_MAX_W'(entry_row) <= NUM_MAX_W'(rows_loaded));
  assign col_ok  = (entry_col != '0) &&
                   (NUM_MAX_W'(entry_col) <= NUM_MAX_W'(cols_loaded));
  assign row_idx = entry_row - ENTRY_W'(1);
  assign col_idx = entry_col - ENTRY_W'(1);

  // Classify the accepted item and build the command for the back part.
  always_comb begin
    rows_loaded_next = rows_loaded;
    rows_kept_next   = rows_kept;
    cols_loaded_next = cols_loaded;
    cols_kept_next   = cols_kept;
    cmd_push         = 1'b0;
    cmd.op           = OP_LOOKUP;
    cmd.row_addr     = ADDR_MAX_W'(row_idx);
    cmd.col_addr     = ADDR_MAX_W'(col_idx);
    cmd.number       = '0;
    cmd.value        = entry_value;
    if (accept) begin
      unique case (kind_t'(kind))
        KIND_CLEAR: begin
          rows_loaded_next = '0;
          rows_kept_next   = '0;
          cols_loaded_next = '0;
          cols_kept_next   = '0;
        end
        KIND_ROW: begin
          if (rows_loaded < RCW'(MAX_ROWS)) begin
            cmd_push         = 1'b1;
            cmd.op           = OP_WR_ROW;
            cmd.row_addr     = ADDR_MAX_W'(rows_loaded);
            rows_loaded_next = rows_loaded + RCW'(1);
            if (keep_flag) begin
              rows_kept_next = rows_kept + RCW'(1);
              cmd.number     = NUM_MAX_W'(rows_kept + RCW'(1));
            end
          end
        end
        KIND_COL: begin
          if (cols_loaded < CCW'(MAX_COLS)) begin
            cmd_push         = 1'b1;
            cmd.op           = OP_WR_COL;
            cmd.col_addr     = ADDR_MAX_W'(cols_loaded);
            cols_loaded_next = cols_loaded + CCW'(1);
            if (keep_flag) begin
              cols_kept_next = cols_kept + CCW'(1);
              cmd.number     = NUM_MAX_W'(cols_kept + CCW'(1));
            end
          end
        end
        KIND_TRIPLET: begin
          cmd_push = row_ok && col_ok;
        end
        default: begin
          cmd_push = 1'b0;
        end
      endcase
    end
  end

  // Load counters of the current subset.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_loaded <= '0;
      rows_kept   <= '0;
      cols_loaded <= '0;
      cols_kept   <= '0;
    end else begin
      rows_loaded <= rows_loaded_next;
      rows_kept   <= rows_kept_next;
      cols_loaded <= cols_loaded_next;
      cols_kept   <= cols_kept_next;
    end
  end

endmodule

### rtl/ssfr_back.sv
module ssfr_back #(
  parameter int MAX_ROWS = 4096,
  parameter int MAX_COLS = 4096
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cmd_empty,
  input  ssfr_pkg::cmd_t                             cmd,
  output logic                                       cmd_pop,
  input  logic [$clog2(ssfr_pkg::RES_Q_DEPTH+1)-1:0] res_count,
  output logic                                       res_push,
  output ssfr_pkg::res_t                             res
);

  import ssfr_pkg::*;

  localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RNW = $clog2(MAX_ROWS + 1);
  localparam int CNW = $clog2(MAX_COLS + 1);
  localparam int QCW = $clog2(RES_Q_DEPTH + 1) + 1;

  logic [RNW-1:0]     row_table [MAX_ROWS];
  logic [CNW-1:0]     col_table [MAX_COLS];
  logic [RNW-1:0]     row_rd;
  logic [CNW-1:0]     col_rd;
  logic [VALUE_W-1:0] value_rd;
  logic               rd_valid;
  logic               room;

  // A lookup goes ahead only if the result queue can take what is in flight.
  assign room    = (QCW'(res_count) + QCW'(rd_valid)) < QCW'(RES_Q_DEPTH);
  assign cmd_pop = !cmd_empty && ((cmd.op != OP_LOOKUP) || room);

  // Numbering tables: one write or one registered read per transfer.
  always_ff @(posedge clk) begin
    if (cmd_pop && (cmd.op == OP_WR_ROW)) begin
      row_table[cmd.row_addr[RAW-1:0]] <= cmd.number[RNW-1:0];
    end
    if (cmd_pop && (cmd.op == OP_LOOKUP)) begin
      row_rd <= row_table[cmd.row_addr[RAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && (cmd.op == OP_WR_COL)) begin
      col_table[cmd.col_addr[CAW-1:0]] <= cmd.number[CNW-1:0];
    end
    if (cmd_pop && (cmd.op == OP_LOOKUP)) begin
      col_rd   <= col_table[cmd.col_addr[CAW-1:0]];
      value_rd <= cmd.value;
    end
  end

  // Read stage valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd_pop && (cmd.op == OP_LOOKUP);
    end
  end

  // Emit a result only when both the row and the column are kept.
  assign res_push      = rd_valid && (row_rd != '0) && (col_rd != '0);
  assign res.new_row   = ENTRY_W'(row_rd);
  assign res.new_col   = ENTRY_W'(col_rd);
  assign res.out_value = value_rd;

endmodule

### rtl/sparse_submatrix_filter_remap.sv
// Sparse submatrix filter: a clear item starts a new subset, row and column
// keep bits then load two numbering tables in order, and each triplet whose
// row and column are both loaded and kept leaves as one result with the
// renumbered row and column and the value unchanged, in stream order.
// Triplets with an index of zero or beyond the loaded masks, and keep bits
// beyond the table size, are dropped. The block takes one item per cycle:
// each item costs at most one write or one read on the single port of each
// numbering table. A result is written to the output queue from the registered
// table reads of its triplet; the four-entry result queue lets the output
// stall without losing items, and the front stalls only when the two-entry
// command queue fills. The tables are not cleared; stale entries are never read.
module sparse_submatrix_filter_remap #(
  parameter int MAX_ROWS = ssfr_pkg::DEFAULT_MAX_ROWS,
  parameter int MAX_COLS = ssfr_pkg::DEFAULT_MAX_COLS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    kind,
  input  logic                          keep_flag,
  input  logic [ssfr_pkg::ENTRY_W-1:0]  entry_row,
  input  logic [ssfr_pkg::ENTRY_W-1:0]  entry_col,
  input  logic [ssfr_pkg::VALUE_W-1:0]  entry_value,
  output logic                          empty,
  input  logic                          pop,
  output logic [ssfr_pkg::ENTRY_W-1:0]  new_row,
  output logic [ssfr_pkg::ENTRY_W-1:0]  new_col,
  output logic [ssfr_pkg::VALUE_W-1:0]  out_value
);

  import ssfr_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  cmd_t                               cmd_in;
  cmd_t                               cmd_out;
  logic                               cmd_push;
  logic                               cmd_pop;
  logic                               cmd_full;
  logic                               cmd_empty;
  logic [$clog2(CMD_Q_DEPTH+1)-1:0]   cmd_count;
  res_t                               res_in;
  res_t                               res_out;
  logic                               res_push;
  logic                               res_full;
  logic [$clog2(RES_Q_DEPTH+1)-1:0]   res_count;

  // Front: accepts and classifies items, keeps the load counters.
  ssfr_front #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .kind       (kind),
    .keep_flag  (keep_flag),
    .entry_row  (entry_row),
    .entry_col  (entry_col),
    .entry_value(entry_value),
    .cmd_full   (cmd_full),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in)
  );

  // Command queue between front and back.
  ssfr_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_push),
    .wr_data(cmd_in),
    .rd_en  (cmd_pop),
    .rd_data(cmd_out),
    .full   (cmd_full),
    .empty  (cmd_empty),
    .count  (cmd_count)
  );

  // Back: numbering tables and lookups.
  ssfr_back #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_empty(cmd_empty),
    .cmd      (cmd_out),
    .cmd_pop  (cmd_pop),
    .res_count(res_count),
    .res_push (res_push),
    .res      (res_in)
  );

  // Result queue facing the output port.
  ssfr_fifo #(
    .WIDTH(RES_W),
    .DEPTH(RES_Q_DEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_push),
    .wr_data(res_in),
    .rd_en  (pop),
    .rd_data(res_out),
    .full   (res_full),
    .empty  (empty),
    .count  (res_count)
  );

  assign new_row   = res_out.new_row;
  assign new_col   = res_out.new_col;
  assign out_value = res_out.out_value;

  // The credit check must keep the result queue from overflowing.
  assert property (@(posedge clk) disable iff (rst) res_push |-> !res_full)
    else $error("result queue written while full");

  // The front must never push into a full command queue.
  assert property (@(posedge clk) disable iff (rst) cmd_push |-> !cmd_full)
    else $error("command queue written while full");

  // A result is pushed in the cycle after a command transfer out of the queue.
  assert property (@(posedge clk) disable iff (rst) res_push |-> $past(cmd_pop))
    else $error("result without a preceding lookup");

  // A popped command must come from a non-empty queue.
  assert property (@(posedge clk) disable iff (rst) cmd_pop |-> (cmd_count != '0))
    else $error("command popped from an empty queue");

endmodule
